/* rtl/rit_pkg.sv */
// Shared types, constants and helpers for the radix integer-to-text unit.
`default_nettype none
package rit_pkg;

  localparam int MAX_DIGITS     = 64;
  localparam int VALUE_W        = 64;
  localparam int RADIX_W        = 5;
  localparam int MIN_W          = 7;
  localparam int CHAR_W         = 7;
  localparam int DIGIT_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 7;
  localparam int ADDR_W         = $clog2(MAX_DIGITS);
  localparam int CNT_W          = $clog2(MAX_DIGITS + 1);
  localparam int BITS_PER_CYCLE = 8;
  localparam int STEP_CYCLES    = VALUE_W / BITS_PER_CYCLE;
  localparam int STEP_W         = $clog2(STEP_CYCLES);

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS = CFG_IDX_W'(1);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [MIN_W-1:0]   MIN_RESET   = MIN_W'(1);
  localparam logic [RADIX_W-1:0] RADIX_LOW   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_HIGH  = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic more;
    logic last_digit;
  } status_t;

  // Map a digit value to uppercase ASCII.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/rit_if.sv */
// Request channels of the radix integer-to-text unit.
`default_nettype none
interface rit_in_if;
  logic                         valid;
  logic                         ready;
  logic [rit_pkg::VALUE_W-1:0]  value;
  logic                         treat_signed;

  modport source (output valid, output value, output treat_signed, input ready);
  modport sink   (input valid, input value, input treat_signed, output ready);
endinterface

interface rit_out_if;
  logic                         valid;
  logic                         ready;
  logic [rit_pkg::CHAR_W-1:0]   digit_char;
  logic                         leading_minus;
  logic                         last;

  modport source (output valid, output digit_char, output leading_minus, output last,
                  input ready);
  modport sink   (input valid, input digit_char, input leading_minus, input last,
                  output ready);
endinterface
`default_nettype wire

/* rtl/rit_ram.sv */
// Generic single-port-write RAM with registered read.
`default_nettype none
module rit_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/rit_ctrl.sv */
// Sequencer for load, division passes and digit emission.
`default_nettype none
module rit_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  output      logic             out_valid,
  input  wire logic             out_ready,
  input  wire rit_pkg::status_t st,
  output      rit_pkg::cmd_t    cmd
);

  rit_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rit_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    case (state)
      rit_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rit_pkg::ST_DIV;
        end
      end
      rit_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last && !st.more) begin
          state_next = rit_pkg::ST_FETCH;
        end
      end
      rit_pkg::ST_FETCH: begin
        // registered RAM read of the current digit; the data is ready in ST_SEND
        state_next = rit_pkg::ST_SEND;
      end
      rit_pkg::ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          state_next  = st.last_digit ? rit_pkg::ST_IDLE : rit_pkg::ST_FETCH;
        end
      end
      default: begin
        state_next = rit_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/rit_dp.sv */
// Datapath: config registers, radix divider, digit store and output fields.
`default_nettype none
module rit_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rit_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rit_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [rit_pkg::VALUE_W-1:0]      value,
  input  wire logic                             treat_signed,
  input  wire rit_pkg::cmd_t                    cmd,
  output      rit_pkg::status_t                 st,
  output      logic [rit_pkg::CHAR_W-1:0]       digit_char,
  output      logic                             leading_minus,
  output      logic                             last
);

  localparam int BPC = rit_pkg::BITS_PER_CYCLE;
  localparam int VW  = rit_pkg::VALUE_W;

  logic [rit_pkg::RADIX_W-1:0] radix_reg;
  logic [rit_pkg::MIN_W-1:0]   min_reg;
  logic [rit_pkg::RADIX_W-1:0] base;
  logic [rit_pkg::CNT_W-1:0]   minc;
  logic                        neg;
  logic [VW-1:0]               mag;
  logic [rit_pkg::DIGIT_W-1:0] rem;
  logic [rit_pkg::STEP_W-1:0]  step;
  logic [rit_pkg::CNT_W-1:0]   count;
  logic [rit_pkg::ADDR_W-1:0]  ptr;
  logic                        first;

  logic [rit_pkg::RADIX_W-1:0] base_eff;
  logic [rit_pkg::CNT_W-1:0]   minc_eff;
  logic [VW-1:0]               mag_next;
  logic [rit_pkg::DIGIT_W-1:0] rem_next;
  logic [BPC-1:0]              qbits;
  logic [rit_pkg::CNT_W-1:0]   count_inc;
  logic [rit_pkg::DIGIT_W-1:0] rd_digit;
  logic                        ram_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg <= rit_pkg::RADIX_RESET;
      min_reg   <= rit_pkg::MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rit_pkg::CFG_RADIX:      radix_reg <= cfg_data[rit_pkg::RADIX_W-1:0];
        rit_pkg::CFG_MIN_DIGITS: min_reg   <= cfg_data[rit_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configured radix and digit count
  always_comb begin
    if (radix_reg < rit_pkg::RADIX_LOW) begin
      base_eff = rit_pkg::RADIX_LOW;
    end else if (radix_reg > rit_pkg::RADIX_HIGH) begin
      base_eff = rit_pkg::RADIX_HIGH;
    end else begin
      base_eff = radix_reg;
    end
    if (min_reg > rit_pkg::MIN_W'(rit_pkg::MAX_DIGITS)) begin
      minc_eff = rit_pkg::CNT_W'(rit_pkg::MAX_DIGITS);
    end else begin
      minc_eff = rit_pkg::CNT_W'(min_reg);
    end
  end

  // Restoring division, a byte of the dividend per cycle, MSB first
  always_comb begin
    logic [rit_pkg::DIGIT_W-1:0] r;
    logic [rit_pkg::DIGIT_W:0]   t;
    r     = rem;
    qbits = '0;
    for (int i = 0; i < BPC; i++) begin
      t = {r, mag[VW-1-i]};
      if (t >= {1'b0, base[rit_pkg::DIGIT_W-1:0]} || base[rit_pkg::DIGIT_W]) begin
        if (t >= base) begin
          qbits[BPC-1-i] = 1'b1;
          t = t - base;
        end
      end
      r = t[rit_pkg::DIGIT_W-1:0];
    end
    rem_next = r;
    mag_next = {mag[VW-BPC-1:0], qbits};
  end

  assign count_inc   = count + rit_pkg::CNT_W'(1);
  assign st.div_last = (step == rit_pkg::STEP_W'(rit_pkg::STEP_CYCLES - 1));
  assign st.more     = (count_inc < rit_pkg::CNT_W'(rit_pkg::MAX_DIGITS)) &&
                       ((count_inc < minc) || (mag_next != '0));
  assign st.last_digit = (ptr == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg   <= treat_signed && value[VW-1];
      mag   <= (treat_signed && value[VW-1]) ? (~value + VW'(1)) : value;
      base  <= base_eff;
      minc  <= minc_eff;
      rem   <= '0;
      step  <= '0;
      count <= '0;
    end else if (cmd.div_step) begin
      mag  <= mag_next;
      step <= step + rit_pkg::STEP_W'(1);
      if (st.div_last) begin
        // digit done: restart remainder, bump count, point at top digit
        rem   <= '0;
        count <= count_inc;
        ptr   <= count[rit_pkg::ADDR_W-1:0];
        first <= 1'b1;
      end else begin
        rem <= rem_next;
      end
    end else if (cmd.advance) begin
      ptr   <= ptr - rit_pkg::ADDR_W'(1);
      first <= 1'b0;
    end
  end

  assign ram_we = cmd.div_step && st.div_last;

  rit_ram #(
    .WIDTH (rit_pkg::DIGIT_W),
    .DEPTH (rit_pkg::MAX_DIGITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[rit_pkg::ADDR_W-1:0]),
    .wdata (rem_next),
    .raddr (ptr),
    .rdata (rd_digit)
  );

  assign digit_char    = rit_pkg::digit_to_char(rd_digit);
  assign leading_minus = first && neg;
  assign last          = st.last_digit;

endmodule
`default_nettype wire

/* rtl/radix_integer_to_text_unit.sv */
// Top level of the radix integer-to-text unit.
//
//  channel  direction  payload                               handshake
//  in_ch    sink       value[63:0], treat_signed             valid/ready
//  out_ch   source     digit_char[6:0], leading_minus, last  valid/ready
//  cfg      write      cfg_index[1:0], cfg_data[6:0]         cfg_we
//
// One number at a time. The divider produces 8 quotient bits per cycle over the
// 64-bit magnitude, one full pass per digit, and stores each digit in the digit
// RAM; the digits are then read back, most significant first, through ST_FETCH
// and ST_SEND.
// rst is synchronous; it restores radix 10 and minimum digit count 1.
// Output stalls hold the current digit; input is refused until the last digit goes.
`default_nettype none
module radix_integer_to_text_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rit_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rit_pkg::CFG_DATA_W-1:0]  cfg_data,
  rit_in_if.sink                               in_ch,
  rit_out_if.source                            out_ch
);

  rit_pkg::cmd_t    cmd;
  rit_pkg::status_t st;

  rit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  rit_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .value         (in_ch.value),
    .treat_signed  (in_ch.treat_signed),
    .cmd           (cmd),
    .st            (st),
    .digit_char    (out_ch.digit_char),
    .leading_minus (out_ch.leading_minus),
    .last          (out_ch.last)
  );

endmodule
`default_nettype wire

/* rtl/rit_checker.sv */
// Port-level checks for the radix integer-to-text unit, bound to the top level.
`default_nettype none
module rit_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rit_pkg::CHAR_W-1:0]    digit_char,
  input wire logic                          leading_minus,
  input wire logic                          last
);

  logic mid;
  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // track being inside a number's digit run
  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (out_acc) begin
      mid <= !last;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input ready while a digit is pending");

  a_no_accept_mid: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !mid)
    else $error("new request taken before the last digit");

  a_minus_first_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mid) |-> !leading_minus)
    else $error("minus flag on a digit other than the first");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
                   (digit_char >= 7'd65 && digit_char <= 7'd70)))
    else $error("digit character out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(digit_char) &&
                                   $stable(leading_minus) && $stable(last)))
    else $error("stalled digit changed");

endmodule

bind radix_integer_to_text_unit rit_checker u_rit_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .digit_char    (out_ch.digit_char),
  .leading_minus (out_ch.leading_minus),
  .last          (out_ch.last)
);
`default_nettype wire
